// ===== design/sorted_key_table_defines.svh =====
// assertion macros shared by the checker
`ifndef SORTED_KEY_TABLE_DEFINES_SVH
`define SORTED_KEY_TABLE_DEFINES_SVH

// property checked out of reset
`define SKT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// property checked through reset as well
`define SKT_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== design/sktbl_pkg.sv =====
`default_nettype none

package sktbl_pkg;

  // defaults for the top level parameters
  localparam int DEPTH_DEF     = 16;
  localparam int KEY_WIDTH_DEF = 16;

  // fixed field widths
  localparam int CMD_W    = 3;
  localparam int POS_W    = 4;
  localparam int STATUS_W = 2;

  // command codes
  typedef enum logic [CMD_W-1:0] {
    CMD_INSERT = 3'd0,
    CMD_DELETE = 3'd1,
    CMD_SEARCH = 3'd2,
    CMD_READ   = 3'd3,
    CMD_CLEAR  = 3'd4
  } cmd_t;

  // result status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2,
    ST_BEYOND    = 2'd3
  } status_t;

  // control broadcast to every cell
  typedef struct packed {
    logic cmp;  // latch compare flags against the key bus
    logic ins;  // open a slot and take the key
    logic del;  // close the slot of the first match
  } cell_ctl_t;

endpackage

`default_nettype wire

// ===== design/sktbl_cell.sv =====
`default_nettype none

module sktbl_cell #(
  parameter int KEY_WIDTH = sktbl_pkg::KEY_WIDTH_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire sktbl_pkg::cell_ctl_t  ctl,
  input  wire logic [KEY_WIDTH-1:0]  key,
  input  wire logic                  in_use,
  input  wire logic                  left_lt,
  input  wire logic [KEY_WIDTH-1:0]  left_entry,
  input  wire logic [KEY_WIDTH-1:0]  right_entry,
  output logic      [KEY_WIDTH-1:0]  entry,
  output logic                       lt,
  output logic                       eq
);
  import sktbl_pkg::*;

  logic [KEY_WIDTH-1:0] entry_r, entry_nxt;
  logic                 lt_r, lt_nxt;
  logic                 eq_r, eq_nxt;

  // compare flags, only meaningful for occupied cells
  always_comb begin
    lt_nxt = lt_r;
    eq_nxt = eq_r;
    if (ctl.cmp) begin
      lt_nxt = in_use && (entry_r < key);
      eq_nxt = in_use && (entry_r == key);
    end
  end

  // shift right on insert, left on delete, from the slot onward
  always_comb begin
    entry_nxt = entry_r;
    if (ctl.ins && !lt_r) begin
      entry_nxt = left_lt ? key : left_entry;
    end else if (ctl.del && !lt_r) begin
      entry_nxt = right_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lt_r <= 1'b0;
      eq_r <= 1'b0;
    end else begin
      lt_r <= lt_nxt;
      eq_r <= eq_nxt;
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

  assign entry = entry_r;
  assign lt    = lt_r;
  assign eq    = eq_r;

endmodule

`default_nettype wire

// ===== design/sorted_key_table.sv =====
// channel  | ports                          | beat contents (lowest bit first)
// in       | in_tvalid/in_tready/in_tdata   | tdata: key, position; tuser: command
// out      | out_tvalid/out_tready/out_tdata| tdata: status, found, value, count, full_res
//
// each command has a compare step, in which every cell compares the key,
// and an update step, which shifts the row of cells and loads the result register.
// a new command is taken only after the previous one has loaded the result register.
// reset clears the count and the handshake state; entries are not cleared.
// when out_tready is low with a result held, the next command waits in execute.
`default_nettype none

module sorted_key_table #(
  parameter  int DEPTH      = sktbl_pkg::DEPTH_DEF,
  parameter  int KEY_WIDTH  = sktbl_pkg::KEY_WIDTH_DEF,
  localparam int CNT_W      = $clog2(DEPTH + 1),
  localparam int IN_BITS    = KEY_WIDTH + sktbl_pkg::POS_W,
  localparam int IN_TD_W    = ((IN_BITS + 7) / 8) * 8,
  localparam int OUT_BITS   = sktbl_pkg::STATUS_W + 2 + KEY_WIDTH + CNT_W,
  localparam int OUT_TD_W   = ((OUT_BITS + 7) / 8) * 8
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_tvalid,
  output logic                             in_tready,
  input  wire logic [IN_TD_W-1:0]          in_tdata,   // key, position
  input  wire logic [sktbl_pkg::CMD_W-1:0] in_tuser,   // command
  output logic                             out_tvalid,
  input  wire logic                        out_tready,
  output logic      [OUT_TD_W-1:0]         out_tdata   // status, found, value, count, full_res
);
  import sktbl_pkg::*;

  localparam int RD_N  = (DEPTH < (1 << POS_W)) ? DEPTH : (1 << POS_W);
  localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EXEC = 2'b10
  } state_t;

  state_t                state_r, state_nxt;
  logic [CMD_W-1:0]      cmd_r;
  logic [KEY_WIDTH-1:0]  key_r;
  logic [POS_W-1:0]      pos_r;
  logic [CNT_W-1:0]      count_r, count_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [OUT_TD_W-1:0]   out_data_r, out_data_nxt;

  logic                  in_fire, exec_fire;
  logic [KEY_WIDTH-1:0]  key_bus;
  cell_ctl_t             ctl;
  logic [DEPTH-1:0]      in_use, lt_w, eq_w;
  logic [KEY_WIDTH-1:0]  entry_w [DEPTH];
  logic [KEY_WIDTH-1:0]  rd_val;
  logic                  found, full_now;
  status_t               status;
  logic                  hit;
  logic [KEY_WIDTH-1:0]  value;

  assign in_tready = (state_r == S_IDLE);
  assign in_fire   = in_tvalid && in_tready;
  assign exec_fire = (state_r == S_EXEC) && (!out_valid_r || out_tready);

  // key bus: incoming key during compare, held key during update
  assign key_bus = (state_r == S_IDLE) ? in_tdata[KEY_WIDTH-1:0] : key_r;

  assign found    = |eq_w;
  assign full_now = (count_r == CNT_W'(DEPTH));

  // row of cells
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic                 l_lt;
    logic [KEY_WIDTH-1:0] l_entry, r_entry;

    assign in_use[i] = (CNT_W'(i) < count_r);

    if (i == 0) begin : g_first
      assign l_lt    = 1'b1;
      assign l_entry = key_bus;
    end else begin : g_mid
      assign l_lt    = lt_w[i-1];
      assign l_entry = entry_w[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign r_entry = entry_w[i];
    end else begin : g_inner
      assign r_entry = entry_w[i+1];
    end

    sktbl_cell #(.KEY_WIDTH(KEY_WIDTH)) u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .ctl         (ctl),
      .key         (key_bus),
      .in_use      (in_use[i]),
      .left_lt     (l_lt),
      .left_entry  (l_entry),
      .right_entry (r_entry),
      .entry       (entry_w[i]),
      .lt          (lt_w[i]),
      .eq          (eq_w[i])
    );
  end

  // read port over the positions the command can address
  always_comb begin
    rd_val = '0;
    for (int i = 0; i < RD_N; i++) begin
      if (pos_r == POS_W'(i)) begin
        rd_val = entry_w[i];
      end
    end
  end

  // command decode for the update cycle
  always_comb begin
    ctl       = '0;
    ctl.cmp   = in_fire;
    count_nxt = count_r;
    status    = ST_OK;
    hit       = 1'b0;
    value     = '0;
    unique case (cmd_r)
      CMD_INSERT: begin
        value = key_r;
        if (full_now) begin
          status = ST_FULL;
        end else begin
          ctl.ins   = exec_fire;
          count_nxt = count_r + CNT_W'(1);
        end
      end
      CMD_DELETE: begin
        value = key_r;
        if (found) begin
          hit       = 1'b1;
          ctl.del   = exec_fire;
          count_nxt = count_r - CNT_W'(1);
        end else begin
          status = ST_NOT_FOUND;
        end
      end
      CMD_SEARCH: begin
        value = key_r;
        hit   = found;
        if (!found) begin
          status = ST_NOT_FOUND;
        end
      end
      CMD_READ: begin
        if (CMP_W'(pos_r) >= CMP_W'(count_r)) begin
          status = ST_BEYOND;
        end else begin
          value = rd_val;
        end
      end
      CMD_CLEAR: begin
        count_nxt = '0;
      end
      default: begin
        count_nxt = count_r;
      end
    endcase
  end

  // result beat packing
  always_comb begin
    out_data_nxt = '0;
    out_data_nxt[STATUS_W-1:0]                      = status;
    out_data_nxt[STATUS_W]                          = hit;
    out_data_nxt[STATUS_W+1 +: KEY_WIDTH]           = value;
    out_data_nxt[STATUS_W+1+KEY_WIDTH +: CNT_W]     = count_nxt;
    out_data_nxt[STATUS_W+1+KEY_WIDTH+CNT_W]        = (count_nxt == CNT_W'(DEPTH));
  end

  // sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (in_fire) state_nxt = S_EXEC;
      S_EXEC: if (exec_fire) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // output register valid
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (exec_fire) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (exec_fire) begin
        count_r <= count_nxt;
      end
    end
  end

  // command capture and result payload
  always_ff @(posedge clk) begin
    if (in_fire) begin
      cmd_r <= in_tuser;
      key_r <= in_tdata[KEY_WIDTH-1:0];
      pos_r <= in_tdata[KEY_WIDTH +: POS_W];
    end
    if (exec_fire) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

`default_nettype wire

// ===== design/sktbl_chk.sv =====
`default_nettype none

`include "sorted_key_table_defines.svh"

module sktbl_chk #(
  parameter  int DEPTH     = sktbl_pkg::DEPTH_DEF,
  parameter  int KEY_WIDTH = sktbl_pkg::KEY_WIDTH_DEF,
  localparam int CNT_W     = $clog2(DEPTH + 1),
  localparam int OUT_TD_W  = ((sktbl_pkg::STATUS_W + 2 + KEY_WIDTH + CNT_W + 7) / 8) * 8
) (
  input wire logic                        clk,
  input wire logic                        rst_n,
  input wire logic                        in_tvalid,
  input wire logic                        in_tready,
  input wire logic                        out_tvalid,
  input wire logic                        out_tready,
  input wire logic [OUT_TD_W-1:0]         out_tdata
);
  import sktbl_pkg::*;

  localparam int CNT_LSB  = STATUS_W + 1 + KEY_WIDTH;
  localparam int FULL_BIT = CNT_LSB + CNT_W;

  logic [CNT_W-1:0] cnt_f;
  logic             full_f;
  logic             in_fire;

  assign cnt_f   = out_tdata[CNT_LSB +: CNT_W];
  assign full_f  = out_tdata[FULL_BIT];
  assign in_fire = in_tvalid && in_tready;

  // no result beat straight out of reset
  `SKT_ASSERT_RST(a_rst_quiet, $past(!rst_n) |-> !out_tvalid, "result valid after reset")

  // a held result beat stays until taken
  `SKT_ASSERT(a_hold, (out_tvalid && !out_tready) |=> out_tvalid, "result beat dropped")

  // count never exceeds the table depth
  `SKT_ASSERT(a_cnt_max, out_tvalid |-> (cnt_f <= CNT_W'(DEPTH)), "count above depth")

  // full flag tracks the count
  `SKT_ASSERT(a_full, out_tvalid |-> (full_f == (cnt_f == CNT_W'(DEPTH))), "full flag mismatch")

  // a command occupies the compare and update cycles
  `SKT_ASSERT(a_two_cyc, in_fire |=> !in_tready, "command taken in back to back cycles")

endmodule

bind sorted_key_table sktbl_chk #(
  .DEPTH     (DEPTH),
  .KEY_WIDTH (KEY_WIDTH)
) u_sktbl_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

`default_nettype wire

// ===== verif/sorted_key_table_test.sv =====
`default_nettype none

module sorted_key_table_test;
  timeunit 1ns;
  timeprecision 1ps;

  import sktbl_pkg::*;

  localparam int TBL_DEPTH = DEPTH_DEF;
  localparam int KEY_W     = KEY_WIDTH_DEF;
  localparam int CNT_W     = $clog2(TBL_DEPTH + 1);
  localparam int IN_BITS   = KEY_W + POS_W;
  localparam int IN_TD_W   = ((IN_BITS + 7) / 8) * 8;
  localparam int OUT_BITS  = STATUS_W + 2 + KEY_W + CNT_W;
  localparam int OUT_TD_W  = ((OUT_BITS + 7) / 8) * 8;

  localparam int CYCLE_LIMIT   = 400000;
  localparam int SETTLE_CYCLES = 16;
  localparam int PHASE_ITEMS   = 560;
  localparam int MAX_REPORTS   = 10;

  // command codes the block does not define
  localparam logic [CMD_W-1:0] CMD_SPARE_FIRST = 3'd5;
  localparam logic [CMD_W-1:0] CMD_SPARE_LAST  = 3'd7;

  // one command beat as the generator sees it
  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic [KEY_W-1:0] key;
    logic [POS_W-1:0] pos;
  } cmd_beat_t;

  // result beat layout, lowest bit last in the list
  typedef struct packed {
    logic [OUT_TD_W-OUT_BITS-1:0] pad;
    logic                         full_res;
    logic [CNT_W-1:0]             count;
    logic [KEY_W-1:0]             value;
    logic                         found;
    status_t                      status;
  } result_t;

  logic                clk;
  logic                rst_n;
  logic                in_tvalid;
  logic                in_tready;
  logic [IN_TD_W-1:0]  in_tdata;   // key, position
  logic [CMD_W-1:0]    in_tuser;   // command
  logic                out_tvalid;
  logic                out_tready;
  logic [OUT_TD_W-1:0] out_tdata;  // status, found, value, count, full_res

  cmd_beat_t        cmd_backlog[$];
  result_t          pending_results[$];
  logic [KEY_W-1:0] recent_keys[$];

  // shadow copy of the key table
  logic [KEY_W-1:0] shadow_keys[TBL_DEPTH];
  int               shadow_count;

  cmd_beat_t cur_beat;
  bit        in_taken;
  int        send_idle;
  int        recv_idle;
  int        fail_cnt;
  int        cycle_cnt;

  sorted_key_table u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  // clock
  always #10 clk = ~clk;

  // run the command against the shadow table and return the result it owes
  function automatic result_t table_apply(input cmd_beat_t b);
    result_t r;
    int      slot;
    int      i;
    r = '0;
    r.status = ST_OK;
    case (b.cmd)
      CMD_INSERT: begin
        r.value = b.key;
        if (shadow_count >= TBL_DEPTH) begin
          r.status = ST_FULL;
        end else begin
          slot = 0;
          while (slot < shadow_count && shadow_keys[slot] < b.key) slot++;
          for (i = shadow_count; i > slot; i--) shadow_keys[i] = shadow_keys[i - 1];
          shadow_keys[slot] = b.key;
          shadow_count++;
        end
      end
      CMD_DELETE, CMD_SEARCH: begin
        r.value = b.key;
        slot = shadow_count;
        for (i = shadow_count - 1; i >= 0; i--) begin
          if (shadow_keys[i] == b.key) slot = i;
        end
        if (slot >= shadow_count) begin
          r.status = ST_NOT_FOUND;
        end else begin
          r.found = 1'b1;
          if (b.cmd == CMD_DELETE) begin
            for (i = slot; i + 1 < shadow_count; i++) shadow_keys[i] = shadow_keys[i + 1];
            shadow_count--;
          end
        end
      end
      CMD_READ: begin
        if (b.pos >= shadow_count) r.status = ST_BEYOND;
        else r.value = shadow_keys[b.pos];
      end
      CMD_CLEAR: begin
        shadow_count = 0;
      end
      default: begin
      end
    endcase
    r.count    = shadow_count[CNT_W-1:0];
    r.full_res = (shadow_count == TBL_DEPTH);
    return r;
  endfunction

  // mostly recently inserted keys or their neighbors, so hits and duplicates are common
  function automatic logic [KEY_W-1:0] pick_key();
    int               r;
    logic [KEY_W-1:0] k;
    r = $urandom_range(99);
    k = KEY_W'($urandom());
    if (recent_keys.size() != 0 && r < 60) begin
      k = recent_keys[$urandom_range(recent_keys.size() - 1)];
      if (r >= 50) k = k + 1'b1;
    end else if (r < 66) begin
      k = '0;
    end else if (r < 72) begin
      k = '1;
    end
    return k;
  endfunction

  // filling runs favor inserts, draining runs favor deletes and clears
  function automatic cmd_beat_t random_beat(input bit filling);
    cmd_beat_t b;
    int        r;
    r = $urandom_range(99);
    b.key = pick_key();
    b.pos = POS_W'($urandom());
    if (r < (filling ? 45 : 12)) begin
      b.cmd = CMD_INSERT;
      recent_keys.push_back(b.key);
      if (recent_keys.size() > 24) void'(recent_keys.pop_front());
    end else if (r < (filling ? 60 : 50)) begin
      b.cmd = CMD_DELETE;
    end else if (r < 72) begin
      b.cmd = CMD_SEARCH;
    end else if (r < 90) begin
      b.cmd = CMD_READ;
    end else if (r < (filling ? 91 : 95)) begin
      b.cmd = CMD_CLEAR;
    end else begin
      b.cmd = CMD_W'($urandom_range(CMD_SPARE_LAST, CMD_SPARE_FIRST));
    end
    return b;
  endfunction

  task automatic push_beat(input logic [CMD_W-1:0] cmd, input logic [KEY_W-1:0] key,
                           input logic [POS_W-1:0] pos);
    cmd_beat_t b;
    b.cmd = cmd;
    b.key = key;
    b.pos = pos;
    cmd_backlog.push_back(b);
  endtask

  task automatic note_fail(input string msg);
    fail_cnt++;
    if (fail_cnt <= MAX_REPORTS) $display("%s", msg);
  endtask

  // hold until every queued beat is taken and every result is back
  task automatic wait_idle();
    while (cmd_backlog.size() != 0 || in_tvalid || pending_results.size() != 0)
      @(posedge clk);
  endtask

  // command driver
  always @(negedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_taken) begin
      if (cmd_backlog.size() != 0 && $urandom_range(99) >= send_idle) begin
        cur_beat = cmd_backlog.pop_front();
        in_tdata  <= {{(IN_TD_W - IN_BITS){1'b0}}, cur_beat.pos, cur_beat.key};
        in_tuser  <= cur_beat.cmd;
        in_tvalid <= 1'b1;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
    in_taken = 1'b0;
    out_tready <= ($urandom_range(99) >= recv_idle);
  end

  // beat monitor: predict on accepted commands, check accepted results
  always @(posedge clk) begin : beat_monitor
    result_t got;
    result_t want;
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        pending_results.push_back(table_apply(cur_beat));
        in_taken = 1'b1;
      end
      if (out_tvalid && out_tready) begin
        got = result_t'(out_tdata);
        if (pending_results.size() == 0) begin
          note_fail($sformatf("unexpected result beat %h", out_tdata));
        end else begin
          want = pending_results.pop_front();
          if (got.status !== want.status || got.found !== want.found ||
              got.value !== want.value || got.count !== want.count ||
              got.full_res !== want.full_res)
            note_fail($sformatf({"result mismatch: exp st=%0d fd=%0d val=%h cnt=%0d full=%0d",
                                 " got st=%0d fd=%0d val=%h cnt=%0d full=%0d"},
                                want.status, want.found, want.value, want.count, want.full_res,
                                got.status, got.found, got.value, got.count, got.full_res));
        end
      end
    end
  end

  // run limit
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    int phase;
    int n;
    int run_left;
    bit filling;
    clk          = 1'b0;
    rst_n        = 1'b0;
    in_tvalid    = 1'b0;
    in_tdata     = '0;
    in_tuser     = '0;
    out_tready   = 1'b0;
    in_taken     = 1'b0;
    cur_beat     = '0;
    shadow_count = 0;
    fail_cnt     = 0;
    cycle_cnt    = 0;
    send_idle    = 25;
    recv_idle    = 72;
    filling      = 1'b1;
    run_left     = 0;

    // synchronous reset
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;

    // empty table: search miss, read beyond, delete miss, unknown command
    push_beat(CMD_SEARCH, '0, '0);
    push_beat(CMD_READ, '0, '0);
    push_beat(CMD_DELETE, '1, '0);
    push_beat(CMD_SPARE_LAST, '1, '1);
    // extremes, a duplicate, reads and hits
    push_beat(CMD_INSERT, '1, '0);
    push_beat(CMD_INSERT, '0, '0);
    push_beat(CMD_INSERT, 16'h8000, '0);
    push_beat(CMD_INSERT, 16'h8000, '0);
    push_beat(CMD_READ, '0, 4'd3);
    push_beat(CMD_READ, '0, '0);
    push_beat(CMD_SEARCH, 16'h8000, '0);
    push_beat(CMD_DELETE, 16'h8000, '0);
    // fill up, then insert into a full table
    for (n = 0; n < TBL_DEPTH - 3; n++) push_beat(CMD_INSERT, KEY_W'($urandom()), '0);
    push_beat(CMD_INSERT, 16'h1234, '0);
    push_beat(CMD_READ, '0, '1);
    push_beat(CMD_CLEAR, '1, '1);
    push_beat(CMD_READ, '0, '0);

    for (phase = 0; phase < 3; phase++) begin
      for (n = 0; n < PHASE_ITEMS; n++) begin
        if (run_left == 0) begin
          filling  = ~filling;
          run_left = $urandom_range(90, 30);
        end
        run_left--;
        cmd_backlog.push_back(random_beat(filling));
      end
      wait_idle();
      send_idle = (phase == 0) ? 72 : 0;
      recv_idle = (phase == 0) ? 25 : 0;
    end

    repeat (SETTLE_CYCLES) @(posedge clk);
    if (pending_results.size() != 0)
      note_fail($sformatf("%0d results never arrived", pending_results.size()));
    if (fail_cnt == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== filelist.f =====
+incdir+design
design/sktbl_pkg.sv
design/sktbl_cell.sv
design/sorted_key_table.sv
design/sktbl_chk.sv
verif/sorted_key_table_test.sv
